/* hdl/gfd_pkg.sv */
// gfd_pkg: shared types and constants of the gamepad frame deframer
// used by the channel interfaces, the frame parser and the top level
package gfd_pkg;

  localparam int ByteW  = 8;
  localparam int WordW  = 16;
  localparam int CntW   = 5;

  localparam int FrameLen = 18;
  localparam int SumPos   = 17;
  localparam int BtnPos   = 14;
  localparam int DpadPos  = 16;
  localparam int StickPos = 2;
  localparam int TrigPos  = 10;

  localparam logic [ByteW-1:0] HdrFirst  = 8'hAA;
  localparam logic [ByteW-1:0] HdrSecond = 8'h55;

  typedef enum logic {
    CMD_BYTE  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                    connected;
    logic                    frame_ok;
    logic signed [WordW-1:0] left_x;
    logic signed [WordW-1:0] left_y;
    logic signed [WordW-1:0] right_x;
    logic signed [WordW-1:0] right_y;
    logic [WordW-1:0]        left_trigger;
    logic [WordW-1:0]        right_trigger;
    logic [WordW-1:0]        buttons;
    logic [ByteW-1:0]        dpad;
    logic [WordW-1:0]        pressed_bits;
    logic                    pressed_hit;
  } res_t;

endpackage

/* hdl/gfd_in_if.sv */
// gfd_in_if: input channel of the deframer, one byte or latch query per transfer
// depends on gfd_pkg
interface gfd_in_if;
  import gfd_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [ByteW-1:0] rx_byte;
  logic [WordW-1:0] query_mask;

  modport source (output valid, command, rx_byte, query_mask, input ready);
  modport sink   (input valid, command, rx_byte, query_mask, output ready);
endinterface

/* hdl/gfd_out_if.sv */
// gfd_out_if: result channel of the deframer, one result per input transfer
// depends on gfd_pkg
interface gfd_out_if;
  import gfd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    connected;
  logic                    frame_ok;
  logic signed [WordW-1:0] left_x;
  logic signed [WordW-1:0] left_y;
  logic signed [WordW-1:0] right_x;
  logic signed [WordW-1:0] right_y;
  logic [WordW-1:0]        left_trigger;
  logic [WordW-1:0]        right_trigger;
  logic [WordW-1:0]        buttons;
  logic [ByteW-1:0]        dpad;
  logic [WordW-1:0]        pressed_bits;
  logic                    pressed_hit;

  modport source (output valid, connected, frame_ok, left_x, left_y, right_x, right_y,
                  left_trigger, right_trigger, buttons, dpad, pressed_bits,
                  pressed_hit, input ready);
  modport sink   (input valid, connected, frame_ok, left_x, left_y, right_x, right_y,
                  left_trigger, right_trigger, buttons, dpad, pressed_bits,
                  pressed_hit, output ready);
endinterface

/* hdl/gfd_parser.sv */
// gfd_parser: header hunt, byte capture, checksum and field unpack, press latch
// depends on gfd_pkg; the result is the state after the current transfer
module gfd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  gfd_pkg::cmd_e command_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [15:0]   query_mask_i,
  output gfd_pkg::res_t res_o
);
  import gfd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [ByteW-1:0]        sum_q, sum_d;
  logic [ByteW-1:0]        store_q [FrameLen];
  logic signed [WordW-1:0] stick_q [4];
  logic signed [WordW-1:0] stick_d [4];
  logic [WordW-1:0]        trig_q [2];
  logic [WordW-1:0]        trig_d [2];
  logic [WordW-1:0]        btn_q, btn_d;
  logic [ByteW-1:0]        dpad_q, dpad_d;
  logic [WordW-1:0]        latch_q, latch_d;
  logic                    seen_q, seen_d;

  logic                    store_we;
  logic [CntW-1:0]         store_idx;
  logic                    frame_ok;
  logic                    hit;
  logic [WordW-1:0]        new_btn;

  assign new_btn = {store_q[BtnPos+1], store_q[BtnPos]};

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    sum_d     = sum_q;
    stick_d   = stick_q;
    trig_d    = trig_q;
    btn_d     = btn_q;
    dpad_d    = dpad_q;
    latch_d   = latch_q;
    seen_d    = seen_q;
    store_we  = 1'b0;
    store_idx = count_q;
    frame_ok  = 1'b0;
    hit       = 1'b0;

    if (command_i == CMD_QUERY) begin
      hit     = |(latch_q & query_mask_i);
      latch_d = latch_q & ~query_mask_i;
    end else begin
      case (phase_q)
        PH_HEAD: begin
          if (rx_byte_i == HdrSecond) begin
            store_we  = 1'b1;
            store_idx = CntW'(1);
            count_d   = CntW'(2);
            sum_d     = sum_q + rx_byte_i;
            phase_d   = PH_DATA;
          end else if (rx_byte_i == HdrFirst) begin
            count_d = CntW'(1);
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_DATA: begin
          store_we = (count_q < CntW'(FrameLen));
          if (count_q < CntW'(SumPos)) begin
            sum_d   = sum_q + rx_byte_i;
            count_d = count_q + CntW'(1);
          end else begin
            count_d = CntW'(FrameLen);
            phase_d = PH_HUNT;
            if (sum_q == rx_byte_i) begin
              for (int k = 0; k < 4; k++) begin
                stick_d[k] = {store_q[StickPos+2*k+1], store_q[StickPos+2*k]};
              end
              for (int k = 0; k < 2; k++) begin
                trig_d[k] = {store_q[TrigPos+2*k+1], store_q[TrigPos+2*k]};
              end
              btn_d    = new_btn;
              dpad_d   = store_q[DpadPos];
              // button level doubles as the previous-frame buttons for edge detection
              latch_d  = latch_q | (new_btn & ~btn_q);
              seen_d   = 1'b1;
              frame_ok = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == HdrFirst) begin
            store_we  = 1'b1;
            store_idx = CntW'(0);
            count_d   = CntW'(1);
            sum_d     = HdrFirst;
            phase_d   = PH_HEAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
      sum_q   <= '0;
      stick_q <= '{default: '0};
      trig_q  <= '{default: '0};
      btn_q   <= '0;
      dpad_q  <= '0;
      latch_q <= '0;
      seen_q  <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      stick_q <= stick_d;
      trig_q  <= trig_d;
      btn_q   <= btn_d;
      dpad_q  <= dpad_d;
      latch_q <= latch_d;
      seen_q  <= seen_d;
    end
  end

  // frame bytes, no reset
  always_ff @(posedge clk_i) begin
    if (take_i && store_we) begin
      store_q[store_idx] <= rx_byte_i;
    end
  end

  always_comb begin
    res_o.connected     = seen_d;
    res_o.frame_ok      = frame_ok;
    res_o.left_x        = stick_d[0];
    res_o.left_y        = stick_d[1];
    res_o.right_x       = stick_d[2];
    res_o.right_y       = stick_d[3];
    res_o.left_trigger  = trig_d[0];
    res_o.right_trigger = trig_d[1];
    res_o.buttons       = btn_d;
    res_o.dpad          = dpad_d;
    res_o.pressed_bits  = latch_d;
    res_o.pressed_hit   = hit;
  end

endmodule

/* hdl/gamepad_frame_deframer_unit.sv */
// gamepad_frame_deframer_unit: top level of the gamepad frame deframer
// depends on gfd_pkg, gfd_in_if, gfd_out_if and gfd_parser
//
// usage
//   in_i carries one item per transfer: a received byte (command 0) or a
//   query of the press latch (command 1, query_mask selects the bits to test
//   and clear)
//   out_o returns exactly one result per input transfer, in order: stick,
//   trigger, button and dpad values of the last good frame, connected,
//   frame_ok for the byte that closed a good frame, the press latch and the
//   query answer
//   each result is registered: it goes to the result register, or to the skid register behind a held result
//   throughput is one item per cycle while in_i.ready is high; the parser
//   state, checksum and field unpack all settle in one pass between the state
//   registers and the result register
//   a two-entry result buffer (result register plus skid register) lets the
//   input keep taking items while a result waits; in_i.ready drops only when
//   both entries are full, so a stalled receiver holds at most two results
//   reset clears the parser to header hunt, all fields, the latch and the
//   connected flag; the frame byte store is not cleared and needs no sweep
module gamepad_frame_deframer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  gfd_in_if.sink    in_i,
  gfd_out_if.source out_o
);
  import gfd_pkg::*;

  logic  take;
  logic  pop;
  res_t  res;
  res_t  out_q, skid_q;
  logic  out_valid_q, skid_valid_q;

  // input stays open until the skid entry is occupied
  assign in_i.ready = !skid_valid_q;
  assign take       = in_i.valid && in_i.ready;
  assign pop        = out_valid_q && out_o.ready;

  gfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .command_i    (cmd_e'(in_i.command)),
    .rx_byte_i    (in_i.rx_byte),
    .query_mask_i (in_i.query_mask),
    .res_o        (res)
  );

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= take;
      end
    end else if (take) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (take) begin
        out_q <= res;
      end
    end else if (take) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.connected     = out_q.connected;
  assign out_o.frame_ok      = out_q.frame_ok;
  assign out_o.left_x        = out_q.left_x;
  assign out_o.left_y        = out_q.left_y;
  assign out_o.right_x       = out_q.right_x;
  assign out_o.right_y       = out_q.right_y;
  assign out_o.left_trigger  = out_q.left_trigger;
  assign out_o.right_trigger = out_q.right_trigger;
  assign out_o.buttons       = out_q.buttons;
  assign out_o.dpad          = out_q.dpad;
  assign out_o.pressed_bits  = out_q.pressed_bits;
  assign out_o.pressed_hit   = out_q.pressed_hit;

`ifndef SYNTHESIS
  // the skid entry is only ever filled behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without a result in the output register");

  // a transfer into a stalled full result register lands in the skid entry
  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && out_valid_q && !out_o.ready) |=> skid_valid_q)
    else $error("result lost while receiver stalled");

  // a good frame always reports the link as connected
  a_ok_connected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_ok) |-> out_q.connected)
    else $error("frame_ok without connected");

  // query answers and frame completion never share a result
  a_hit_not_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.frame_ok && out_q.pressed_hit))
    else $error("frame_ok and pressed_hit in the same result");
`endif

endmodule
